@@ rtl/fletcher16_frame_builder_top_macros.svh @@
// Assertion macros for the Fletcher-16 frame builder.
`ifndef FLETCHER16_FRAME_BUILDER_TOP_MACROS_SVH
`define FLETCHER16_FRAME_BUILDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define FBF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fbf assertion failed");
`define FBF_ASSERT_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("fbf assertion failed");
`else
`define FBF_ASSERT(lbl, prop)
`define FBF_ASSERT_NEXT(lbl, cond, nxt)
`endif

`endif

@@ rtl/fbf_pkg.sv @@
// Shared types, constants and helpers of the Fletcher-16 frame builder.
package fbf_pkg;

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [7:0] BYTE_MAX = 8'hff;

  localparam logic FUNC_HDR = 1'b0;
  localparam logic FUNC_PAY = 1'b1;

  typedef enum logic {
    CMD_HDR = 1'b0,
    CMD_PAY = 1'b1
  } cmd_kind_t;

  // One frame command: header carries three bytes, payload uses b0 only.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } fbf_cmd_t;

  typedef enum logic [2:0] {
    ST_D0,
    ST_D1,
    ST_D2,
    ST_C0,
    ST_C1
  } step_t;

  // (a + b) mod 255 for a <= 254, b <= 255.
  function automatic logic [7:0] mod255_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, BYTE_MAX}) begin
      s = s - {1'b0, BYTE_MAX};
    end
    return s[7:0];
  endfunction

endpackage

@@ rtl/fbf_front.sv @@
// Front end: accepts items, tracks the open frame and issues commands.
module fbf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic             in_func,
  input  logic [7:0]       in_msg_type,
  input  logic [7:0]       in_data_id,
  input  logic [7:0]       in_frame_len,
  input  logic [7:0]       in_payload_byte,
  input  logic             q_full,
  output logic             q_push,
  output fbf_pkg::fbf_cmd_t q_cmd
);

  logic       open_r, open_nxt;
  logic [7:0] left_r, left_nxt;
  logic       acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  always_comb begin
    q_cmd    = '{kind: fbf_pkg::CMD_PAY, b0: 8'd0, b1: 8'd0, b2: 8'd0, last: 1'b0};
    q_push   = 1'b0;
    open_nxt = open_r;
    left_nxt = left_r;
    if (acc) begin
      if (in_func == fbf_pkg::FUNC_HDR) begin
        q_cmd.kind = fbf_pkg::CMD_HDR;
        q_cmd.b0   = in_msg_type;
        q_cmd.b1   = in_data_id;
        q_cmd.b2   = in_frame_len;
        q_cmd.last = (in_frame_len == 8'd0);
        q_push     = 1'b1;
        open_nxt   = (in_frame_len != 8'd0);
        left_nxt   = in_frame_len;
      end else if (open_r) begin
        q_cmd.b0   = in_payload_byte;
        q_cmd.last = (left_r == 8'd1);
        q_push     = 1'b1;
        left_nxt   = left_r - 8'd1;
        if (left_r == 8'd1) begin
          open_nxt = 1'b0;
        end
      end
      // payload with no frame open: dropped
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      left_r <= 8'd0;
    end else begin
      open_r <= open_nxt;
      left_r <= left_nxt;
    end
  end

endmodule

@@ rtl/fbf_cmdq.sv @@
// Short command queue between front and back end.
`include "fletcher16_frame_builder_top_macros.svh"

module fbf_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  fbf_pkg::fbf_cmd_t wr_cmd,
  output logic              q_full,
  input  logic              rd_en,
  output fbf_pkg::fbf_cmd_t rd_cmd,
  output logic              q_empty
);

  fbf_pkg::fbf_cmd_t            mem_r [fbf_pkg::CMDQ_DEPTH];
  logic [fbf_pkg::CMDQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [fbf_pkg::CMDQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [fbf_pkg::CMDQ_AW:0]    count_r, count_nxt;
  logic                         do_wr, do_rd;

  assign q_full  = (count_r == (fbf_pkg::CMDQ_AW+1)'(fbf_pkg::CMDQ_DEPTH));
  assign q_empty = (count_r == '0);
  assign rd_cmd  = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  `FBF_ASSERT(a_cmdq_count_bound, count_r <= (fbf_pkg::CMDQ_AW+1)'(fbf_pkg::CMDQ_DEPTH))
  `FBF_ASSERT_NEXT(a_cmdq_ptr_track, do_wr && !do_rd && !q_full, !q_empty)
  `FBF_ASSERT(a_cmdq_empty_ptrs, !q_empty || wr_ptr_r == rd_ptr_r)

endmodule

@@ rtl/fbf_back.sv @@
// Back end: walks each command byte by byte, keeps the sums, appends check bytes.
`include "fletcher16_frame_builder_top_macros.svh"

module fbf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fbf_pkg::fbf_cmd_t q_cmd,
  input  logic              q_empty,
  output logic              q_pop,
  output logic [7:0]        out_byte,
  output logic              out_frame_end,
  output logic              empty,
  input  logic              pop
);

  logic              busy_r, busy_nxt;
  fbf_pkg::fbf_cmd_t cur_r, cur_nxt;
  fbf_pkg::step_t    step_r, step_nxt, step_next;
  logic [7:0]        low_r, low_nxt, high_r, high_nxt, c0_r, c0_nxt;
  logic              ov_r, ov_nxt, oe_r, oe_nxt;
  logic [7:0]        ob_r, ob_nxt;

  logic              adv, fin, is_data, emit_end;
  logic [7:0]        emit_byte, base_low, base_high, sum_low, sum_high, c0_val, c1_val;

  assign adv           = !ov_r || pop;
  assign empty         = !ov_r;
  assign out_byte      = ob_r;
  assign out_frame_end = oe_r;

  // header restarts the sums at its first byte
  assign base_low  = (cur_r.kind == fbf_pkg::CMD_HDR && step_r == fbf_pkg::ST_D0) ? 8'd0 : low_r;
  assign base_high = (cur_r.kind == fbf_pkg::CMD_HDR && step_r == fbf_pkg::ST_D0) ? 8'd0 : high_r;
  assign sum_low   = fbf_pkg::mod255_add(base_low, emit_byte);
  assign sum_high  = fbf_pkg::mod255_add(base_high, sum_low);
  assign c0_val    = fbf_pkg::BYTE_MAX - fbf_pkg::mod255_add(low_r, high_r);
  assign c1_val    = fbf_pkg::BYTE_MAX - fbf_pkg::mod255_add(low_r, c0_r);

  always_comb begin
    emit_byte = 8'd0;
    emit_end  = 1'b0;
    is_data   = 1'b0;
    fin       = 1'b0;
    step_next = fbf_pkg::ST_D0;
    unique case (step_r)
      fbf_pkg::ST_D0: begin
        emit_byte = cur_r.b0;
        is_data   = 1'b1;
        if (cur_r.kind == fbf_pkg::CMD_HDR) begin
          step_next = fbf_pkg::ST_D1;
        end else if (cur_r.last) begin
          step_next = fbf_pkg::ST_C0;
        end else begin
          fin = 1'b1;
        end
      end
      fbf_pkg::ST_D1: begin
        emit_byte = cur_r.b1;
        is_data   = 1'b1;
        step_next = fbf_pkg::ST_D2;
      end
      fbf_pkg::ST_D2: begin
        emit_byte = cur_r.b2;
        is_data   = 1'b1;
        if (cur_r.last) begin
          step_next = fbf_pkg::ST_C0;
        end else begin
          fin = 1'b1;
        end
      end
      fbf_pkg::ST_C0: begin
        emit_byte = c0_val;
        step_next = fbf_pkg::ST_C1;
      end
      fbf_pkg::ST_C1: begin
        emit_byte = c1_val;
        emit_end  = 1'b1;
        fin       = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    cur_nxt  = cur_r;
    step_nxt = step_r;
    low_nxt  = low_r;
    high_nxt = high_r;
    c0_nxt   = c0_r;
    ov_nxt   = ov_r;
    ob_nxt   = ob_r;
    oe_nxt   = oe_r;
    q_pop    = 1'b0;

    if (busy_r && adv) begin
      ov_nxt   = 1'b1;
      ob_nxt   = emit_byte;
      oe_nxt   = emit_end;
      step_nxt = step_next;
      if (is_data) begin
        low_nxt  = sum_low;
        high_nxt = sum_high;
      end
      if (step_r == fbf_pkg::ST_C0) begin
        c0_nxt = c0_val;
      end
      if (fin) begin
        busy_nxt = 1'b0;
      end
    end else if (adv) begin
      ov_nxt = 1'b0;
    end

    // pick up the next command as soon as the current one finishes
    if ((!busy_r || (adv && fin)) && !q_empty) begin
      q_pop    = 1'b1;
      cur_nxt  = q_cmd;
      busy_nxt = 1'b1;
      step_nxt = fbf_pkg::ST_D0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= fbf_pkg::ST_D0;
      ov_r   <= 1'b0;
      low_r  <= 8'd0;
      high_r <= 8'd0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      ov_r   <= ov_nxt;
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    c0_r  <= c0_nxt;
    ob_r  <= ob_nxt;
    oe_r  <= oe_nxt;
  end

  `FBF_ASSERT(a_idle_step, busy_r || step_r == fbf_pkg::ST_D0)
  `FBF_ASSERT(a_sums_reduced, low_r != fbf_pkg::BYTE_MAX && high_r != fbf_pkg::BYTE_MAX)
  `FBF_ASSERT_NEXT(a_check_pair, busy_r && adv && step_r == fbf_pkg::ST_C0,
                   busy_r && step_r == fbf_pkg::ST_C1)
  `FBF_ASSERT_NEXT(a_end_on_c1, busy_r && adv && step_r == fbf_pkg::ST_C1, ov_r && oe_r)

endmodule

@@ rtl/fletcher16_frame_builder_top.sv @@
// Fletcher-16 frame builder: top level.
//
// Input channel: push/full with fields in_func, in_msg_type, in_data_id,
// in_frame_len, in_payload_byte. A header item (func 0) yields the type, id
// and length bytes; a payload item (func 1) yields its byte. After the last
// payload byte, or right after a zero-length header, two check bytes follow
// so a receiver's Fletcher-16 sums over the frame end at zero. A payload item
// with no frame open is taken and dropped.
// Result channel: empty/pop with out_byte and out_frame_end (set on the
// second check byte). The oldest byte is held while empty is low and pop is low.
// An item's first byte passes through the command queue, the back end's
// command register and the output byte register. Throughput: one output byte
// per cycle while pop keeps up; an item produces 1 byte (a plain payload byte)
// or 3 to 5 bytes (headers and frame ends), emitted one byte per cycle.
// A 4-entry command queue parts the front end from the byte sequencer; full
// rises when it fills, either because pop is held low or because items come
// faster than their bytes leave.
// Reset clears the queue, the open-frame state and the output valid flag.
module fletcher16_frame_builder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_func,
  input  logic [7:0] in_msg_type,
  input  logic [7:0] in_data_id,
  input  logic [7:0] in_frame_len,
  input  logic [7:0] in_payload_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_frame_end
);

  fbf_pkg::fbf_cmd_t wr_cmd, rd_cmd;
  logic              q_full, q_empty, q_push, q_pop;

  fbf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_msg_type     (in_msg_type),
    .in_data_id      (in_data_id),
    .in_frame_len    (in_frame_len),
    .in_payload_byte (in_payload_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (wr_cmd)
  );

  fbf_cmdq u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_cmd  (wr_cmd),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_cmd  (rd_cmd),
    .q_empty (q_empty)
  );

  fbf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_cmd         (rd_cmd),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

@@ bench/fletcher16_frame_builder_checker.sv @@
// Checker for the Fletcher-16 frame builder: predicts frame bytes and compares them.
module fletcher16_frame_builder_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic       in_func,
  input  logic [7:0] in_msg_type,
  input  logic [7:0] in_data_id,
  input  logic [7:0] in_frame_len,
  input  logic [7:0] in_payload_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       out_frame_end,
  output int         fail_count,
  output int         pending,
  output int         checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] b;
    logic       is_end;
  } tx_byte_t;

  tx_byte_t   expected_tx_q[$];
  tx_byte_t   head;
  logic [7:0] sum_lo;
  logic [7:0] sum_hi;
  logic [7:0] payload_left;
  logic       in_frame;
  int         n_err = 0;
  int         n_chk = 0;

  task automatic queue_tx(input logic [7:0] b, input logic is_end);
    tx_byte_t e;
    e.b      = b;
    e.is_end = is_end;
    expected_tx_q.push_back(e);
  endtask

  // Frame byte that also goes into both running sums (mod 255).
  task automatic emit_byte(input logic [7:0] b);
    int unsigned acc;
    queue_tx(b, 1'b0);
    acc    = (sum_lo + b) % 255;
    sum_lo = acc[7:0];
    acc    = (sum_hi + sum_lo) % 255;
    sum_hi = acc[7:0];
  endtask

  task automatic predict_frame_bytes(input logic f, input logic [7:0] t, input logic [7:0] id,
                                     input logic [7:0] len, input logic [7:0] pb);
    logic        close;
    logic [7:0]  c0;
    logic [7:0]  c1;
    int unsigned acc;
    close = 1'b0;
    if (f == fbf_pkg::FUNC_HDR) begin
      // a header always restarts the sums, abandoning any open frame
      sum_lo = 8'd0;
      sum_hi = 8'd0;
      emit_byte(t);
      emit_byte(id);
      emit_byte(len);
      payload_left = len;
      in_frame     = (len != 8'd0);
      close        = (len == 8'd0);
    end else if (in_frame) begin
      emit_byte(pb);
      payload_left = payload_left - 8'd1;
      close        = (payload_left == 8'd0);
    end
    // payload with no frame open: dropped, nothing to predict
    if (close) begin
      acc = (sum_lo + sum_hi) % 255;
      c0  = fbf_pkg::BYTE_MAX - acc[7:0];
      acc = (sum_lo + c0) % 255;
      c1  = fbf_pkg::BYTE_MAX - acc[7:0];
      queue_tx(c0, 1'b0);
      queue_tx(c1, 1'b1);
      in_frame     = 1'b0;
      payload_left = 8'd0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sum_lo       = 8'd0;
      sum_hi       = 8'd0;
      payload_left = 8'd0;
      in_frame     = 1'b0;
      expected_tx_q.delete();
    end else begin
      // a byte leaving now can't come from an item taken at this same edge
      if (pop && !empty) begin
        n_chk++;
        if (expected_tx_q.size() == 0) begin
          $error("unexpected frame byte: out_byte %0h out_frame_end %0b",
                 out_byte, out_frame_end);
          n_err++;
        end else begin
          head = expected_tx_q.pop_front();
          if (out_byte !== head.b) begin
            $error("out_byte: expected %0h, actual %0h", head.b, out_byte);
            n_err++;
          end
          if (out_frame_end !== head.is_end) begin
            $error("out_frame_end: expected %0b, actual %0b", head.is_end, out_frame_end);
            n_err++;
          end
        end
      end
      if (push && !full) begin
        predict_frame_bytes(in_func, in_msg_type, in_data_id, in_frame_len, in_payload_byte);
      end
    end
    fail_count <= n_err;
    pending    <= expected_tx_q.size();
    checked    <= n_chk;
  end

endmodule

@@ bench/fletcher16_frame_builder_top_tb.sv @@
// Testbench top for the Fletcher-16 frame builder: clock, reset, stimulus and verdict.
module fletcher16_frame_builder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 120;
  localparam int ITEM_BUDGET    = 220;
  localparam int QUIET_FROM     = 185;

  logic       clk             = 1'b0;
  logic       rst_n           = 1'b0;
  logic       push            = 1'b0;
  logic       in_func         = fbf_pkg::FUNC_HDR;
  logic [7:0] in_msg_type     = 8'd0;
  logic [7:0] in_data_id      = 8'd0;
  logic [7:0] in_frame_len    = 8'd0;
  logic [7:0] in_payload_byte = 8'd0;
  logic       pop             = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_frame_end;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  int   frame_left   = 0;
  int   n_items      = 0;
  int   n_headers    = 0;
  int   n_payload    = 0;
  int   n_dropped    = 0;
  int   n_empty_frm  = 0;
  int   n_cut_short  = 0;
  int   full_stalls  = 0;
  int   idle_cycles  = 0;
  int   hold_req     = 0;
  logic quiet        = 1'b0;
  logic rushing      = 1'b0;

  always #5ns clk = ~clk;

  fletcher16_frame_builder_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_msg_type     (in_msg_type),
    .in_data_id      (in_data_id),
    .in_frame_len    (in_frame_len),
    .in_payload_byte (in_payload_byte),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end)
  );

  fletcher16_frame_builder_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_msg_type     (in_msg_type),
    .in_data_id      (in_data_id),
    .in_frame_len    (in_frame_len),
    .in_payload_byte (in_payload_byte),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked         (checked)
  );

  // Offers one item and returns at the edge where the transaction happens.
  task automatic send_item(input logic f, input logic [7:0] t, input logic [7:0] id,
                           input logic [7:0] len, input logic [7:0] pb);
    if (!quiet && !rushing && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push            <= 1'b1;
    in_func         <= f;
    in_msg_type     <= t;
    in_data_id      <= id;
    in_frame_len    <= len;
    in_payload_byte <= pb;
    do @(posedge clk); while (full);
    n_items++;
  endtask

  task automatic send_header(input logic [7:0] t, input logic [7:0] id, input logic [7:0] len);
    if (frame_left != 0) n_cut_short++;
    if (len == 8'd0) n_empty_frm++;
    frame_left = len;
    n_headers++;
    send_item(fbf_pkg::FUNC_HDR, t, id, len, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload(input logic [7:0] b);
    if (frame_left == 0) begin
      n_dropped++;
    end else begin
      frame_left--;
    end
    n_payload++;
    send_item(fbf_pkg::FUNC_PAY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)), b);
  endtask

  task automatic send_frame(input int len, input int sent);
    send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'(len));
    repeat (sent) send_payload(8'($urandom_range(0, 255)));
  endtask

  task automatic random_frame();
    int r;
    int len;
    int sent;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      // stray payload; dropped unless a cut-short frame is still open
      repeat ($urandom_range(1, 2)) send_payload(8'($urandom_range(0, 255)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) len = 0;
      else if (r < 85) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 40);
      sent = len;
      if (len > 1 && $urandom_range(0, 9) == 0) sent = $urandom_range(0, len - 1);
      send_frame(len, sent);
    end
  endtask

  task automatic drain_frames();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Result side: random stall bursts, plus a long hold-off when requested.
  initial begin
    int hold_seen;
    hold_seen = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any transaction on either side.
  always @(posedge clk) begin
    if (push && full) full_stalls++;
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", idle_cycles);
      $display("fletcher16_frame_builder_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int frame_no;
    frame_no = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: dropped byte, empty frames, extreme bytes, abandoned frames
    send_payload(8'hff);
    send_header(8'h00, 8'h00, 8'd0);
    send_header(8'hff, 8'hff, 8'd0);
    send_header(8'hff, 8'h00, 8'd1);
    send_payload(8'hff);
    send_header(8'h00, 8'hff, 8'd2);
    send_payload(8'h00);
    send_payload(8'hff);
    send_header(8'h5a, 8'ha5, 8'd3);
    send_payload(8'haa);
    send_payload(8'h55);
    send_header(8'h01, 8'h80, 8'd1);
    send_payload(8'h80);
    send_payload(8'h7f);
    send_header(8'h80, 8'h7f, 8'd255);
    send_payload(8'h01);
    send_payload(8'hfe);
    send_header(8'hc3, 8'h3c, 8'd0);

    while (n_items < ITEM_BUDGET) begin
      quiet = (n_items >= QUIET_FROM);
      unique case (frame_no)
        4: begin
          // receiver holds off while frames keep coming, so the queue backs up
          rushing = 1'b1;
          hold_req++;
          send_frame(24, 24);
          rushing = 1'b0;
        end
        8: begin
          drain_frames();
          random_frame();
        end
        12: send_frame(64, 64);
        default: random_frame();
      endcase
      frame_no++;
    end

    quiet = 1'b1;
    drain_frames();
    repeat (20) @(posedge clk);

    $display("covered %0d items: %0d headers (%0d zero-length, %0d abandoned),",
             n_items, n_headers, n_empty_frm, n_cut_short);
    $display("  %0d payload (%0d dropped); %0d frame bytes checked, full stalls %0d cycles",
             n_payload, n_dropped, checked, full_stalls);
    if (fail_count == 0 && pending == 0) begin
      $display("fletcher16_frame_builder_top_tb: PASS");
    end else begin
      $display("fletcher16_frame_builder_top_tb: FAIL");
    end
    $finish;
  end

endmodule
